>>> hdl/iff_pkg.sv
`timescale 1ns / 1ps

package iff_pkg;

    localparam int MAX_DIGITS = 32;
    localparam int DIG_VEC = 4 * MAX_DIGITS;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;

    localparam logic [127:0] DIGIT_CHARS = "fedcba9876543210";

    localparam int FLG_LEFT   = 0;
    localparam int FLG_ZERO   = 1;
    localparam int FLG_SIGNED = 2;
    localparam int FLG_PLUS   = 3;

    // digits[3:0] holds the most significant digit
    typedef struct packed {
        logic [DIG_VEC-1:0] digits;
        logic [5:0]         ndig;
        logic               sign_en;
        logic               neg;
        logic [6:0]         pad;
        logic               zero;
        logic               left;
        logic [6:0]         room;
        logic [6:0]         total;
    } job_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return DIGIT_CHARS[{d, 3'b000} +: 8];
    endfunction

endpackage

>>> hdl/iff_front.sv
`timescale 1ns / 1ps

module iff_front
    import iff_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_WIDTH  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    input  logic [4:0]  base,
    input  logic [6:0]  min_width,
    input  logic [3:0]  format_flags,
    input  logic [6:0]  room,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    localparam int DIV_BITS  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int DIV_STEPS = DIV_BITS / 8;
    localparam int CW        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t               state_reg, state_next;
    logic [DIV_BITS-1:0]   work_reg, work_next;
    logic [3:0]            rem_reg, rem_next;
    logic [CW-1:0]         step_reg, step_next;
    logic [DIG_VEC-1:0]    digits_reg, digits_next;
    logic [5:0]            ndig_reg, ndig_next;
    logic [4:0]            base_reg, base_next;
    logic [6:0]            width_reg, width_next;
    logic [6:0]            room_reg, room_next;
    logic                  left_reg, left_next;
    logic                  zero_reg, zero_next;
    logic                  sign_en_reg, sign_en_next;
    logic                  neg_reg, neg_next;

    logic [VALUE_BITS-1:0] mag;
    logic                  neg_in;
    logic [4:0]            r;
    logic [7:0]            qbits;
    logic [DIV_BITS+7:0]   shifted;
    logic [DIV_BITS-1:0]   work_shift;
    logic [6:0]            used;
    logic [6:0]            pad;

    // 8 quotient bits per cycle
    always_comb
    begin
        r = {1'b0, rem_reg};
        qbits = '0;
        for (int j = 0; j < 8; j++)
        begin
            r = {r[3:0], work_reg[DIV_BITS-1-j]};
            if (r >= base_reg)
            begin
                r = r - base_reg;
                qbits[7-j] = 1'b1;
            end
        end
        shifted = {work_reg, qbits};
        work_shift = shifted[DIV_BITS-1:0];
    end

    assign mag    = value[VALUE_BITS-1:0];
    assign neg_in = format_flags[FLG_SIGNED] & mag[VALUE_BITS-1];

    assign used = 7'(ndig_reg) + 7'(sign_en_reg);
    assign pad  = (width_reg > used) ? (width_reg - used) : 7'd0;

    assign busy   = (state_reg != F_IDLE);
    assign q_push = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        q_job.digits  = digits_reg;
        q_job.ndig    = ndig_reg;
        q_job.sign_en = sign_en_reg;
        q_job.neg     = neg_reg;
        q_job.pad     = pad;
        q_job.zero    = zero_reg;
        q_job.left    = left_reg;
        q_job.room    = room_reg;
        q_job.total   = used + pad;
    end

    always_comb
    begin
        state_next   = state_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        digits_next  = digits_reg;
        ndig_next    = ndig_reg;
        base_next    = base_reg;
        width_next   = width_reg;
        room_next    = room_reg;
        left_next    = left_reg;
        zero_next    = zero_reg;
        sign_en_next = sign_en_reg;
        neg_next     = neg_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    work_next    = DIV_BITS'(neg_in ? (~mag + 1'b1) : mag);
                    rem_next     = '0;
                    step_next    = '0;
                    digits_next  = '0;
                    ndig_next    = '0;
                    base_next    = (base < 5'd2) ? 5'd2 : ((base > 5'd16) ? 5'd16 : base);
                    width_next   = (min_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : min_width;
                    room_next    = room;
                    left_next    = format_flags[FLG_LEFT];
                    zero_next    = format_flags[FLG_ZERO] & ~format_flags[FLG_LEFT];
                    neg_next     = neg_in;
                    sign_en_next = neg_in |
                                   (format_flags[FLG_SIGNED] & format_flags[FLG_PLUS]);
                    state_next   = F_DIV;
                end
            end
            F_DIV:
            begin
                work_next = work_shift;
                if (step_reg == CW'(DIV_STEPS - 1))
                begin
                    digits_next = {digits_reg[DIG_VEC-5:0], r[3:0]};
                    ndig_next   = ndig_reg + 6'd1;
                    rem_next    = '0;
                    step_next   = '0;
                    if (work_shift == '0)
                    begin
                        state_next = F_PUSH;
                    end
                end
                else
                begin
                    rem_next  = r[3:0];
                    step_next = step_reg + 1'b1;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        digits_reg  <= digits_next;
        ndig_reg    <= ndig_next;
        base_reg    <= base_next;
        width_reg   <= width_next;
        room_reg    <= room_next;
        left_reg    <= left_next;
        zero_reg    <= zero_next;
        sign_en_reg <= sign_en_next;
        neg_reg     <= neg_next;
    end

endmodule

>>> hdl/iff_queue.sv
`timescale 1ns / 1ps

module iff_queue
    import iff_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign head_job = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

>>> hdl/iff_back.sv
`timescale 1ns / 1ps

module iff_back
    import iff_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_head,
    output logic       q_pop,
    output logic       strobe,
    output logic [7:0] out_char,
    output logic       stored,
    output logic       last
);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_SIGN  = 5'b00010,
        B_PAD   = 5'b00100,
        B_DIG   = 5'b01000,
        B_TRAIL = 5'b10000
    } bstate_t;

    bstate_t            state_reg, state_next;
    logic [DIG_VEC-1:0] digits_reg, digits_next;
    logic [5:0]         ndig_reg, ndig_next;
    logic [6:0]         pad_reg, pad_next;
    logic               neg_reg, neg_next;
    logic               zero_reg, zero_next;
    logic               left_reg, left_next;
    logic [6:0]         room_reg, room_next;
    logic [6:0]         total_reg, total_next;
    logic [6:0]         k_reg, k_next;
    logic               strobe_reg, strobe_next;
    logic [7:0]         char_reg, char_next;
    logic               stored_reg, stored_next;
    logic               last_reg, last_next;

    logic               emit;

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign strobe   = strobe_reg;
    assign out_char = char_reg;
    assign stored   = stored_reg;
    assign last     = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        digits_next = digits_reg;
        ndig_next   = ndig_reg;
        pad_next    = pad_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        left_next   = left_reg;
        room_next   = room_reg;
        total_next  = total_reg;
        k_next      = k_reg;
        char_next   = char_reg;
        emit        = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    digits_next = q_head.digits;
                    ndig_next   = q_head.ndig;
                    pad_next    = q_head.pad;
                    neg_next    = q_head.neg;
                    zero_next   = q_head.zero;
                    left_next   = q_head.left;
                    room_next   = q_head.room;
                    total_next  = q_head.total;
                    k_next      = '0;
                    if (q_head.sign_en)
                    begin
                        state_next = B_SIGN;
                    end
                    else if (!q_head.left && q_head.pad != 7'd0)
                    begin
                        state_next = B_PAD;
                    end
                    else
                    begin
                        state_next = B_DIG;
                    end
                end
            end
            B_SIGN:
            begin
                emit      = 1'b1;
                char_next = neg_reg ? CH_MINUS : CH_PLUS;
                if (!left_reg && pad_reg != 7'd0)
                begin
                    state_next = B_PAD;
                end
                else
                begin
                    state_next = B_DIG;
                end
            end
            B_PAD:
            begin
                emit      = 1'b1;
                char_next = zero_reg ? CH_ZERO : CH_SPACE;
                pad_next  = pad_reg - 7'd1;
                if (pad_reg == 7'd1)
                begin
                    state_next = B_DIG;
                end
            end
            B_DIG:
            begin
                emit        = 1'b1;
                char_next   = digit_char(digits_reg[3:0]);
                digits_next = {4'd0, digits_reg[DIG_VEC-1:4]};
                ndig_next   = ndig_reg - 6'd1;
                if (ndig_reg == 6'd1)
                begin
                    state_next = (left_reg && pad_reg != 7'd0) ? B_TRAIL : B_IDLE;
                end
            end
            B_TRAIL:
            begin
                emit      = 1'b1;
                char_next = CH_SPACE;
                pad_next  = pad_reg - 7'd1;
                if (pad_reg == 7'd1)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        strobe_next = emit;
        stored_next = k_reg < room_reg;
        last_next   = (k_reg == total_reg - 7'd1);
        if (emit)
        begin
            k_next = k_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        ndig_reg   <= ndig_next;
        pad_reg    <= pad_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        left_reg   <= left_next;
        room_reg   <= room_next;
        total_reg  <= total_next;
        k_reg      <= k_next;
        char_reg   <= char_next;
        stored_reg <= stored_next;
        last_reg   <= last_next;
    end

endmodule

>>> hdl/integer_field_formatter.sv
`timescale 1ns / 1ps

// Integer field formatter.
// Input: a transfer takes place at a clock edge with start high and busy low;
// value, base, min_width, format_flags and room are sampled then.
// Output: one character per cycle on out_char with stored and last, marked by
// strobe for exactly one cycle. The receiver cannot stall; characters are
// never held back once emitted.
// The front converts the value to digits with a shared divider that yields
// 8 quotient bits per cycle, so each digit takes one pass over the whole
// value; busy stays high through the division and the push, longer
// while the job queue is full.
// A two-entry job queue sits between the front and the character emitter, so
// a new item is accepted while the previous field is still being emitted.
// The emitter loads a job from the queue in its idle state and then emits the
// field at one character per cycle: sign, leading padding, digits and, when
// left-justified, trailing spaces, up to 64 characters; out_char is registered.
// Reset clears both control paths and the queue; no field is in flight after.

module integer_field_formatter
    import iff_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_WIDTH  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    input  logic [4:0]  base,
    input  logic [6:0]  min_width,
    input  logic [3:0]  format_flags,
    input  logic [6:0]  room,
    output logic        strobe,
    output logic [7:0]  out_char,
    output logic        stored,
    output logic        last
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    job_t push_job;
    job_t head_job;

    iff_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .base         (base),
        .min_width    (min_width),
        .format_flags (format_flags),
        .room         (room),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    iff_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    iff_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (head_job),
        .q_pop    (q_pop),
        .strobe   (strobe),
        .out_char (out_char),
        .stored   (stored),
        .last     (last)
    );

endmodule
